@@ design/gbpe_pkg.sv @@
// Shared types and constants for the glyph bitmap pixel expander.
package gbpe_pkg;

	// Widest values any parameter setting can produce
	localparam int ANCHOR_MAX_W = 32;
	localparam int BASE_MAX_W   = 20;
	localparam int SCALE_REG_W  = 4;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Run queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIRECTION    = 3'd0,
		REG_WIDTH_SCALE  = 3'd1,
		REG_HEIGHT_SCALE = 3'd2,
		REG_INVERT_BITS  = 3'd3,
		REG_TRANSPARENT  = 3'd4,
		REG_GLYPH_WIDTH  = 3'd5,
		REG_FORE_COLOUR  = 3'd6,
		REG_BACK_COLOUR  = 3'd7
	} reg_index_t;

	// Rotation codes
	localparam logic [1:0] DIR_NORMAL = 2'd0;
	localparam logic [1:0] DIR_ROT90  = 2'd1;
	localparam logic [1:0] DIR_ROT180 = 2'd2;
	localparam logic [1:0] DIR_ROT270 = 2'd3;

	typedef struct packed {
		logic              glyph_bit;
		logic              glyph_start;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [15:0]        pixel_colour;
		logic               run_last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]             direction;
		logic [SCALE_REG_W-1:0] width_scale;
		logic [SCALE_REG_W-1:0] height_scale;
		logic                   invert_bits;
		logic                   transparent_mode;
		logic [7:0]             glyph_width;
		logic [15:0]            fore_colour;
		logic [15:0]            back_colour;
	} cfg_t;

	// One run of scaled pixel writes, as handed from front to back
	typedef struct packed {
		logic [ANCHOR_MAX_W-1:0] anchor_x;
		logic [ANCHOR_MAX_W-1:0] anchor_y;
		logic [BASE_MAX_W-1:0]   col_base;
		logic [BASE_MAX_W-1:0]   row_base;
		logic [SCALE_REG_W-1:0]  w_scale;
		logic [SCALE_REG_W-1:0]  h_scale;
		logic [1:0]              direction;
		logic [15:0]             colour;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ design/gbpe_front.sv @@
// Front end: glyph position tracking and run setup for each accepted bit.
module gbpe_front #(
	parameter int COORD_BITS = 16,
	parameter int COUNT_BITS = 8,
	parameter int MAX_SCALE  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbpe_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  gbpe_pkg::in_item_t in_item,
	input  gbpe_pkg::q_status_t q_status,
	output logic              push,
	output gbpe_pkg::job_t    push_job
);

	localparam int SW = $clog2(MAX_SCALE + 1);
	localparam int PW = COUNT_BITS + SW;
	localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [gbpe_pkg::SCALE_REG_W-1:0] SCALE_LIMIT =
		gbpe_pkg::SCALE_REG_W'(MAX_SCALE);

	logic [COORD_BITS-1:0] anchor_x_q, anchor_y_q;
	logic [COUNT_BITS-1:0] col_q, row_q;

	logic                  accept;
	logic [COORD_BITS-1:0] ax, ay;
	logic [COUNT_BITS-1:0] col_eff, row_eff, col_next;
	logic                  bit_eff, emit, col_wrap;
	logic [SW-1:0]         ws, hs;
	logic [PW-1:0]         col_base, row_base;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	// Position of this bit: a glyph start reloads origin and clears counters
	always_comb begin
		if (in_item.glyph_start) begin
			ax      = COORD_BITS'($signed(in_item.origin_x));
			ay      = COORD_BITS'($signed(in_item.origin_y));
			col_eff = '0;
			row_eff = '0;
		end else begin
			ax      = anchor_x_q;
			ay      = anchor_y_q;
			col_eff = col_q;
			row_eff = row_q;
		end
	end

	// Clamp scales to the supported maximum
	assign ws = (cfg.width_scale > SCALE_LIMIT) ? SW'(MAX_SCALE) : SW'(cfg.width_scale);
	assign hs = (cfg.height_scale > SCALE_LIMIT) ? SW'(MAX_SCALE) : SW'(cfg.height_scale);

	// Draw decision and base offsets of the run
	assign bit_eff  = in_item.glyph_bit ^ cfg.invert_bits;
	assign emit     = (bit_eff || !cfg.transparent_mode) && (ws != '0) && (hs != '0);
	assign col_base = PW'(col_eff) * PW'(ws);
	assign row_base = PW'(row_eff) * PW'(hs);

	assign push = accept && emit;

	always_comb begin
		push_job           = '0;
		push_job.anchor_x  = gbpe_pkg::ANCHOR_MAX_W'(ax);
		push_job.anchor_y  = gbpe_pkg::ANCHOR_MAX_W'(ay);
		push_job.col_base  = gbpe_pkg::BASE_MAX_W'(col_base);
		push_job.row_base  = gbpe_pkg::BASE_MAX_W'(row_base);
		push_job.w_scale   = gbpe_pkg::SCALE_REG_W'(ws);
		push_job.h_scale   = gbpe_pkg::SCALE_REG_W'(hs);
		push_job.direction = cfg.direction;
		push_job.colour    = bit_eff ? cfg.fore_colour : cfg.back_colour;
	end

	// Column advance, wrapping at the glyph width into the next row
	assign col_next = col_eff + 1'b1;
	assign col_wrap = (CMP_W'(col_next) >= CMP_W'(cfg.glyph_width)) || (col_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (accept) begin
			anchor_x_q <= ax;
			anchor_y_q <= ay;
			col_q      <= col_wrap ? '0 : col_next;
			row_q      <= col_wrap ? row_eff + 1'b1 : row_eff;
		end
	end

endmodule

@@ design/gbpe_queue.sv @@
// Short run queue between the front and back ends.
module gbpe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gbpe_pkg::job_t      wr_data,
	input  logic                pop,
	output gbpe_pkg::job_t      rd_data,
	output gbpe_pkg::q_status_t status
);

	localparam int CNT_W = gbpe_pkg::QUEUE_PTR_W + 1;

	gbpe_pkg::job_t                   mem_q [gbpe_pkg::QUEUE_DEPTH];
	logic [gbpe_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]                 count_q;

	assign status.full  = (count_q == CNT_W'(gbpe_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_data      = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ design/gbpe_back.sv @@
// Back end: walks one run of scaled pixels and drives the output register.
module gbpe_back #(
	parameter int COORD_BITS = 16,
	parameter int COUNT_BITS = 8,
	parameter int MAX_SCALE  = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gbpe_pkg::q_status_t q_status,
	input  gbpe_pkg::job_t      head_job,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output gbpe_pkg::out_item_t out_item
);

	localparam int SW = $clog2(MAX_SCALE + 1);
	localparam int PW = COUNT_BITS + SW;

	logic                busy_q, out_valid_q;
	gbpe_pkg::job_t      job_q;
	logic [SW-1:0]       wi_q, hi_q;
	gbpe_pkg::out_item_t out_q;

	logic                  step, last_w, last_h;
	logic [SW-1:0]         ws, hs;
	logic [PW-1:0]         along_p, down_p;
	logic [COORD_BITS-1:0] along, down, ax, ay, px, py;

	assign pop = !busy_q && !q_status.empty;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// One write per cycle while the output register is free
	assign step   = busy_q && (!out_valid_q || out_ready);
	assign ws     = SW'(job_q.w_scale);
	assign hs     = SW'(job_q.h_scale);
	assign last_w = (wi_q == ws - 1'b1);
	assign last_h = (hi_q == hs - 1'b1);

	// Pixel offset and rotation
	assign along_p = PW'(job_q.col_base) + PW'(wi_q);
	assign down_p  = PW'(job_q.row_base) + PW'(hi_q);
	assign along   = COORD_BITS'(along_p);
	assign down    = COORD_BITS'(down_p);
	assign ax      = COORD_BITS'(job_q.anchor_x);
	assign ay      = COORD_BITS'(job_q.anchor_y);

	always_comb begin
		case (job_q.direction)
			gbpe_pkg::DIR_ROT90: begin
				px = ax - down;
				py = ay + along;
			end
			gbpe_pkg::DIR_ROT180: begin
				px = ax - along;
				py = ay - down;
			end
			gbpe_pkg::DIR_ROT270: begin
				px = ax + down;
				py = ay - along;
			end
			default: begin
				px = ax + along;
				py = ay + down;
			end
		endcase
	end

	// Run control: load from queue, width count outer, height count inner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			wi_q        <= '0;
			hi_q        <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				wi_q   <= '0;
				hi_q   <= '0;
			end else if (step) begin
				if (last_h) begin
					hi_q <= '0;
					wi_q <= wi_q + 1'b1;
					if (last_w) busy_q <= 1'b0;
				end else begin
					hi_q <= hi_q + 1'b1;
				end
			end
			if (step)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Run payload and output payload
	always_ff @(posedge clk) begin
		if (pop) job_q <= head_job;
		if (step) begin
			out_q.pixel_x      <= 16'(px);
			out_q.pixel_y      <= 16'(py);
			out_q.pixel_colour <= job_q.colour;
			out_q.run_last     <= last_w && last_h;
		end
	end

endmodule

@@ design/glyph_bitmap_pixel_expander.sv @@
// Top level of the glyph bitmap pixel expander: config registers and block wiring.
// Takes one glyph bit per transfer and emits width_scale x height_scale pixel writes per
// drawn bit (scales clamp at MAX_SCALE; a zero scale, or a transparent bit that is zero
// after invert_bits, draws nothing), rotated by direction and coloured from fore_colour
// or back_colour; run_last marks the final write of a bit. The back end loads each run
// from the two-entry queue, then produces one pixel per cycle while its output register
// is free; the front takes a bit every cycle while that queue has room, and bits that
// draw nothing push no run. The first write of a bit goes through the run queue, the run
// register and the output register. Configuration writes take effect on the next bit.
module glyph_bitmap_pixel_expander #(
	parameter int COORD_BITS = 16,
	parameter int COUNT_BITS = 8,
	parameter int MAX_SCALE  = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [gbpe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gbpe_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  gbpe_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output gbpe_pkg::out_item_t                 out_item
);

	gbpe_pkg::cfg_t      cfg_q;
	gbpe_pkg::q_status_t q_status;
	gbpe_pkg::job_t      push_job, head_job;
	logic                push, pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction        <= gbpe_pkg::DIR_NORMAL;
			cfg_q.width_scale      <= 4'd1;
			cfg_q.height_scale     <= 4'd1;
			cfg_q.invert_bits      <= 1'b0;
			cfg_q.transparent_mode <= 1'b0;
			cfg_q.glyph_width      <= 8'd8;
			cfg_q.fore_colour      <= 16'hFFFF;
			cfg_q.back_colour      <= 16'h0000;
		end else if (cfg_write) begin
			case (cfg_index)
				gbpe_pkg::REG_DIRECTION:    cfg_q.direction        <= cfg_data[1:0];
				gbpe_pkg::REG_WIDTH_SCALE:  cfg_q.width_scale      <= cfg_data[3:0];
				gbpe_pkg::REG_HEIGHT_SCALE: cfg_q.height_scale     <= cfg_data[3:0];
				gbpe_pkg::REG_INVERT_BITS:  cfg_q.invert_bits      <= cfg_data[0];
				gbpe_pkg::REG_TRANSPARENT:  cfg_q.transparent_mode <= cfg_data[0];
				gbpe_pkg::REG_GLYPH_WIDTH:  cfg_q.glyph_width      <= cfg_data[7:0];
				gbpe_pkg::REG_FORE_COLOUR:  cfg_q.fore_colour      <= cfg_data;
				gbpe_pkg::REG_BACK_COLOUR:  cfg_q.back_colour      <= cfg_data;
				default: ;
			endcase
		end
	end

	gbpe_front #(
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS),
		.MAX_SCALE (MAX_SCALE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item (in_item),
		.q_status(q_status),
		.push    (push),
		.push_job(push_job)
	);

	gbpe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(push_job),
		.pop    (pop),
		.rd_data(head_job),
		.status (q_status)
	);

	gbpe_back #(
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS),
		.MAX_SCALE (MAX_SCALE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.head_job (head_job),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// Queue never reports full and empty together
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("run queue full and empty at once");

	// Back end never takes a run from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty run queue");

	// Front end never pushes into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full run queue");

	// A run loaded into an idle back end leads to a pending write at the output register
	a_pop_emits: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> ##1 out_valid)
		else $error("loaded run produced no write");

endmodule
